@@ rtl/ptct_pkg.sv @@
`timescale 1ns / 1ps

package ptct_pkg;

    localparam int SLOTS   = 16;
    localparam int MAX_OUT = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = 32;
    localparam int BIT_W   = $clog2(CNT_W);
    localparam int NFIRE_W = $clog2(MAX_OUT + 1);
    localparam int H_W     = 16;
    localparam int D_W     = 16;
    localparam int SLOT_W  = 4;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ATTACH = 2'd1,
        CMD_DETACH = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_FIRE   = 2'd0,
        KIND_ATTACH = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_DETACH = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TSCAN,
        S_TDIV,
        S_TCHK,
        S_FLUSH,
        S_ASCAN,
        S_DSCAN
    } t_state;

    typedef struct packed {
        t_cmd             command;
        logic [H_W-1:0]   handle;
        logic [D_W-1:0]   divisor;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic [H_W-1:0]     handle_out;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } t_res;

endpackage

@@ rtl/periodic_tick_callback_table.sv @@
`timescale 1ns / 1ps
// Periodic tick callback table.
// Request channel: i_req is taken at a rising edge where start is high and busy
// is low. busy stays high until the final result of the request is registered,
// and falls as that result is strobed. Result channel: o_res is valid for
// exactly one cycle while o_strobe is high; the receiver cannot stall, so each result is taken in its strobe cycle.
// Tick: the 32-bit count advances, then slots are scanned in order. An empty
// slot or one with a zero period is skipped; an occupied slot goes through
// load, 32 restoring-division steps and check in the bit-serial remainder
// unit. A due slot's result is held back until the next due slot is found,
// so the final one can carry last.
// Attach scans for the lowest free slot, one slot per cycle;
// detach sweeps all 16 slots. Each gives one result, strobed in the same
// cycle that busy falls. A request with command 3 is dropped without results.
// Reset (synchronous, active low) clears the count and frees every slot.
module periodic_tick_callback_table
    import ptct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(CNT_W - 1);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [H_W-1:0]       r_handle [SLOTS];
    logic [H_W-1:0]       n_handle [SLOTS];
    logic [D_W-1:0]       r_period [SLOTS];
    logic [D_W-1:0]       n_period [SLOTS];
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [H_W-1:0]       r_h, n_h;
    logic [D_W-1:0]       r_d, n_d;
    logic [CNT_W-1:0]     r_dvd, n_dvd;
    logic [D_W-1:0]       r_rem, n_rem;
    logic [D_W-1:0]       r_dsr, n_dsr;
    logic [BIT_W-1:0]     r_bit, n_bit;
    t_res                 r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    logic [NFIRE_W-1:0]   r_nfire, n_nfire;
    logic                 r_strobe, n_strobe;
    t_res                 r_res, n_res;

    logic [D_W:0]         shifted;
    logic [NFIRE_W-1:0]   nfire_inc;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_handle = r_handle;
        n_period = r_period;
        n_idx    = r_idx;
        n_h      = r_h;
        n_d      = r_d;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_dsr    = r_dsr;
        n_bit    = r_bit;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_nfire  = r_nfire;
        n_strobe = 1'b0;
        n_res    = r_res;
        shifted  = {r_rem, r_dvd[CNT_W-1]};
        nfire_inc = r_nfire + NFIRE_W'(1);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_h      = i_req.handle;
                    n_d      = i_req.divisor;
                    n_idx    = '0;
                    n_pend_v = 1'b0;
                    n_nfire  = '0;
                    unique case (i_req.command)
                        CMD_TICK: begin
                            n_count = r_count + CNT_W'(1);
                            n_state = S_TSCAN;
                        end
                        CMD_ATTACH: n_state = S_ASCAN;
                        CMD_DETACH: n_state = S_DSCAN;
                        CMD_RSVD:   n_state = S_IDLE;
                    endcase
                end
            end

            S_TSCAN: begin
                if (r_handle[r_idx] != '0 && r_period[r_idx] != '0) begin
                    n_dsr   = r_period[r_idx];
                    n_dvd   = r_count;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_state = S_TDIV;
                end else if (r_idx == IDX_LAST) begin
                    n_state = r_pend_v ? S_FLUSH : S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // one restoring-division step per cycle, dividend MSB first
            S_TDIV: begin
                if (shifted >= {1'b0, r_dsr}) begin
                    n_rem = D_W'(shifted - {1'b0, r_dsr});
                end else begin
                    n_rem = shifted[D_W-1:0];
                end
                n_dvd = {r_dvd[CNT_W-2:0], 1'b0};
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == BIT_LAST) begin
                    n_state = S_TCHK;
                end
            end

            S_TCHK: begin
                if (r_rem == '0) begin
                    // release the previous due slot, keep this one back
                    if (r_pend_v) begin
                        n_strobe = 1'b1;
                        n_res    = r_pend;
                    end
                    n_pend.kind       = KIND_FIRE;
                    n_pend.handle_out = r_handle[r_idx];
                    n_pend.slot       = SLOT_W'(r_idx);
                    n_pend.last       = 1'b0;
                    n_pend_v          = 1'b1;
                    n_nfire           = nfire_inc;
                end
                if (r_rem == '0 && nfire_inc == NFIRE_W'(MAX_OUT)) begin
                    n_state = S_FLUSH;
                end else if (r_idx == IDX_LAST) begin
                    n_state = (r_pend_v || r_rem == '0) ? S_FLUSH : S_IDLE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_TSCAN;
                end
            end

            S_FLUSH: begin
                n_strobe   = 1'b1;
                n_res      = r_pend;
                n_res.last = 1'b1;
                n_pend_v   = 1'b0;
                n_state    = S_IDLE;
            end

            S_ASCAN: begin
                if (r_handle[r_idx] == '0) begin
                    n_handle[r_idx]  = r_h;
                    n_period[r_idx]  = r_d;
                    n_strobe         = 1'b1;
                    n_res.kind       = KIND_ATTACH;
                    n_res.handle_out = r_h;
                    n_res.slot       = SLOT_W'(r_idx);
                    n_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_idx == IDX_LAST) begin
                    n_strobe         = 1'b1;
                    n_res.kind       = KIND_FULL;
                    n_res.handle_out = r_h;
                    n_res.slot       = '0;
                    n_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            S_DSCAN: begin
                if (r_h != '0 && r_handle[r_idx] == r_h) begin
                    n_handle[r_idx] = '0;
                end
                if (r_idx == IDX_LAST) begin
                    n_strobe         = 1'b1;
                    n_res.kind       = KIND_DETACH;
                    n_res.handle_out = r_h;
                    n_res.slot       = '0;
                    n_res.last       = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_handle[i] <= '0;
            end
            r_pend_v <= 1'b0;
            r_nfire  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_handle <= n_handle;
            r_pend_v <= n_pend_v;
            r_nfire  <= n_nfire;
            r_strobe <= n_strobe;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_period <= n_period;
        r_idx    <= n_idx;
        r_h      <= n_h;
        r_d      <= n_d;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_dsr    <= n_dsr;
        r_bit    <= n_bit;
        r_pend   <= n_pend;
        r_res    <= n_res;
    end

    a_tick_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.command == CMD_TICK)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("tick count did not advance on tick request");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TDIV) |-> (r_dsr != '0))
        else $error("division running with zero period");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.kind != KIND_FIRE) |-> o_res.last)
        else $error("attach or detach result without last");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last) |=> !o_strobe)
        else $error("result strobed right after last");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (o_strobe && o_res.last && o_res.kind == KIND_FIRE))
        else $error("flush did not issue final fired result");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

import ptct_pkg::*;

class tick_table_scoreboard;
    t_res               expected_q[$];
    logic [CNT_W-1:0]   tick_count;
    logic [H_W-1:0]     slot_handle[SLOTS];
    logic [D_W-1:0]     slot_period[SLOTS];
    int                 errors;
    int                 n_ticks;
    int                 n_fired;
    int                 n_attach;
    int                 n_full;
    int                 n_detach;
    int                 most_due;

    function new();
        tick_count = '0;
        foreach (slot_handle[i]) begin
            slot_handle[i] = '0;
            slot_period[i] = '0;
        end
        errors   = 0;
        n_ticks  = 0;
        n_fired  = 0;
        n_attach = 0;
        n_full   = 0;
        n_detach = 0;
        most_due = 0;
    endfunction

    function void push_result(t_kind kind, logic [H_W-1:0] h, int slot, bit last);
        t_res res;
        res.kind       = kind;
        res.handle_out = h;
        res.slot       = slot[SLOT_W-1:0];
        res.last       = last;
        expected_q.push_back(res);
    endfunction

    // Updates the table state for one accepted request and queues its results.
    function void note_request(t_req req);
        int due[$];
        int free_idx;
        case (req.command)
            CMD_TICK: begin
                tick_count = tick_count + 1'b1;
                n_ticks++;
                for (int i = 0; i < SLOTS && due.size() < MAX_OUT; i++) begin
                    if (slot_handle[i] != '0 && slot_period[i] != '0 &&
                        (tick_count % slot_period[i]) == '0)
                        due.push_back(i);
                end
                foreach (due[k])
                    push_result(KIND_FIRE, slot_handle[due[k]], due[k], k == due.size() - 1);
                n_fired += due.size();
                if (due.size() > most_due)
                    most_due = due.size();
            end
            CMD_ATTACH: begin
                free_idx = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (free_idx < 0 && slot_handle[i] == '0)
                        free_idx = i;
                end
                if (free_idx < 0) begin
                    push_result(KIND_FULL, req.handle, 0, 1'b1);
                    n_full++;
                end else begin
                    slot_handle[free_idx] = req.handle;
                    slot_period[free_idx] = req.divisor;
                    push_result(KIND_ATTACH, req.handle, free_idx, 1'b1);
                    n_attach++;
                end
            end
            CMD_DETACH: begin
                // freed slots keep their period
                if (req.handle != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_handle[i] == req.handle)
                            slot_handle[i] = '0;
                    end
                end
                push_result(KIND_DETACH, req.handle, 0, 1'b1);
                n_detach++;
            end
            default: ;
        endcase
    endfunction

    function void check_result(t_res got);
        t_res exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result kind=%0d handle=%h slot=%0d last=%0b",
                     $time, got.kind, got.handle_out, got.slot, got.last);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.kind !== exp_res.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, exp_res.kind, got.kind);
            errors++;
        end
        if (got.handle_out !== exp_res.handle_out) begin
            $display("%0t: handle_out expected %h actual %h",
                     $time, exp_res.handle_out, got.handle_out);
            errors++;
        end
        if (got.slot !== exp_res.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, exp_res.slot, got.slot);
            errors++;
        end
        if (got.last !== exp_res.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_res.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 420;
    localparam int CALM_TAIL    = 60;
    localparam int DRAIN_CYCLES = 600;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_strobe;
    t_res o_res;

    tick_table_scoreboard sb;
    int n_accepted;
    int cycle_count;

    periodic_tick_callback_table DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // check before noting so a stray result never matches this edge's request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result(o_res);
            if (start && !busy) begin
                sb.note_request(i_req);
                n_accepted++;
            end
        end
    end

    function automatic t_req make_req(t_cmd cmd, logic [H_W-1:0] h, logic [D_W-1:0] d);
        t_req req;
        req.command = cmd;
        req.handle  = h;
        req.divisor = d;
        return req;
    endfunction

    // entered and left just after a falling edge
    task automatic send_request(t_req req);
        int target;
        target = n_accepted + 1;
        start <= 1'b1;
        i_req <= req;
        do @(negedge i_clk); while (n_accepted < target);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [H_W-1:0] pick_handle();
        int p;
        p = $urandom_range(0, 99);
        if (p < 80)
            return H_W'($urandom_range(1, 6));
        else if (p < 92)
            return H_W'($urandom);
        return '0;
    endfunction

    function automatic logic [D_W-1:0] pick_divisor();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return D_W'($urandom_range(1, 6));
        else if (p < 80)
            return '0;
        return D_W'($urandom);
    endfunction

    // prefer a handle that is live in the table so detach actually frees slots
    function automatic logic [H_W-1:0] pick_detach_handle();
        int p;
        int live[$];
        p = $urandom_range(0, 99);
        foreach (sb.slot_handle[i])
            if (sb.slot_handle[i] != '0)
                live.push_back(i);
        if (p < 65 && live.size() > 0)
            return sb.slot_handle[live[$urandom_range(0, live.size() - 1)]];
        else if (p < 85)
            return H_W'($urandom_range(1, 6));
        else if (p < 93)
            return H_W'($urandom);
        return '0;
    endfunction

    task automatic run_directed();
        logic [D_W-1:0] d;
        send_request(make_req(CMD_TICK, '0, '0));             // nothing due
        send_request(make_req(CMD_DETACH, '0, '0));           // null handle
        send_request(make_req(CMD_ATTACH, '0, D_W'(5)));      // slot stays free
        for (int i = 0; i < SLOTS; i++) begin
            if (i == 3)
                d = '0;
            else if (i == 5)
                d = '1;
            else
                d = D_W'((i % 2) + 1);
            send_request(make_req(CMD_ATTACH, (i % 2 == 0) ? '1 : H_W'(i + 1), d));
        end
        send_request(make_req(CMD_ATTACH, H_W'(16'h8001), D_W'(1)));   // table full
        send_request(make_req(CMD_TICK, '0, '0));             // nearly every slot due
        send_request(make_req(CMD_RSVD, '1, '1));
        send_request(make_req(CMD_DETACH, '1, '0));           // frees eight slots
        send_request(make_req(CMD_TICK, '0, '0));
    endtask

    task automatic run_random();
        int   counted;
        int   p;
        bit   idle_on;
        t_req req;
        counted = 0;
        idle_on = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            p = $urandom_range(0, 99);
            if (p < 45)
                req = make_req(CMD_TICK, H_W'($urandom), D_W'($urandom));
            else if (p < 75)
                req = make_req(CMD_ATTACH, pick_handle(), pick_divisor());
            else if (p < 94)
                req = make_req(CMD_DETACH, pick_detach_handle(), D_W'($urandom));
            else
                req = make_req(CMD_RSVD, H_W'($urandom), D_W'($urandom));
            send_request(req);
            if (req.command != CMD_RSVD)
                counted++;
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            if (idle_on && counted < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 5));
        end
        start <= 1'b0;
    endtask

    initial begin
        sb          = new();
        n_accepted  = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random();

        while (sb.expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests: %0d ticks firing %0d slots (up to %0d in one tick),",
                 n_accepted, sb.n_ticks, sb.n_fired, sb.most_due);
        $display("  %0d attaches, %0d attaches to a full table, %0d detaches; %0d errors",
                 sb.n_attach, sb.n_full, sb.n_detach, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
